// ----- design/midpoint_circle_point_generator_defines.svh -----
// ----------------------------------------------------------------------------
// Midpoint circle point generator: assertion macros
// Shared checks used by the RTL of the circle point generator.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_CIRCLE_POINT_GENERATOR_DEFINES_SVH
`define MIDPOINT_CIRCLE_POINT_GENERATOR_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define MCPG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle
`define MCPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/mcpg_pkg.sv -----
// ----------------------------------------------------------------------------
// Midpoint circle point generator: package
// Types and constants shared by controller and datapath, and the octant table.
// ----------------------------------------------------------------------------
package mcpg_pkg;

    // Field widths fixed by the item format
    localparam int RAD_BITS   = 12;
    localparam int DEC_BITS   = 16;
    localparam int COORD_BITS = 13;
    localparam int GROUP_SIZE = 8;
    localparam int IDX_BITS   = $clog2(GROUP_SIZE);

    // Decision variable constants of the midpoint rule
    localparam logic [DEC_BITS-1:0] DEC_INIT    = DEC_BITS'(3);
    localparam logic [DEC_BITS-1:0] DEC_STEP_E  = DEC_BITS'(6);
    localparam logic [DEC_BITS-1:0] DEC_STEP_SE = DEC_BITS'(10);

    localparam logic [IDX_BITS-1:0] IDX_FIRST = '0;
    localparam logic [IDX_BITS-1:0] IDX_LAST  = IDX_BITS'(GROUP_SIZE - 1);

    // Item kinds carried on the input tuser
    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_STEP  = 1'b1
    } t_func;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic                load_circle;
        logic                load_point;
        logic                advance;
        logic [IDX_BITS-1:0] idx;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic active;
    } t_dp_stat;

    // Octant mapping of one symmetric point
    typedef struct packed {
        logic swap;
        logic neg_x;
        logic neg_y;
    } t_oct;

    function automatic t_oct oct_map(input logic [IDX_BITS-1:0] idx);
        t_oct m;
        case (idx)
            3'd0:    m = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
            3'd1:    m = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b0};
            3'd2:    m = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b1};
            3'd3:    m = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b1};
            3'd4:    m = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b0};
            3'd5:    m = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b1};
            3'd6:    m = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b0};
            3'd7:    m = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b1};
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// ----- design/mcpg_ctrl.sv -----
// ----------------------------------------------------------------------------
// Midpoint circle point generator: controller
// Sequences input transactions and the eight points of each step group.
// ----------------------------------------------------------------------------
module mcpg_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_tuser,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    input  mcpg_pkg::t_dp_stat i_stat,
    output mcpg_pkg::t_dp_cmd  o_cmd
);
    import mcpg_pkg::*;

    t_state              r_state, n_state;
    logic [IDX_BITS-1:0] r_idx, n_idx;
    logic                accept;
    logic                last_taken;

    // State and point index registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= IDX_FIRST;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Last point of a group leaves this cycle: a new item may enter alongside
    assign last_taken = (r_state == ST_EMIT) && (r_idx == IDX_LAST) && i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) || last_taken;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_state == ST_EMIT);

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                n_state = ST_IDLE;
            end
            ST_EMIT: begin
                if (i_m_tready) begin
                    if (r_idx == IDX_LAST) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx            = r_idx + 1'b1;
                        o_cmd.load_point = 1'b1;
                        o_cmd.idx        = r_idx + 1'b1;
                        o_cmd.advance    = (r_idx + 1'b1 == IDX_LAST);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Take a new input transaction
        if (accept) begin
            if (t_func'(i_s_tuser) == FUNC_START) begin
                o_cmd.load_circle = 1'b1;
            end else if (i_stat.active) begin
                n_state          = ST_EMIT;
                n_idx            = IDX_FIRST;
                o_cmd.load_point = 1'b1;
                o_cmd.idx        = IDX_FIRST;
            end
        end
    end

endmodule

// ----- design/mcpg_datapath.sv -----
// ----------------------------------------------------------------------------
// Midpoint circle point generator: datapath
// Holds the circle state, applies the midpoint rule and forms each point.
// ----------------------------------------------------------------------------
module mcpg_datapath #(
    parameter int COORD_BITS = mcpg_pkg::COORD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mcpg_pkg::t_dp_cmd                   i_cmd,
    output mcpg_pkg::t_dp_stat                  o_stat,
    input  logic [mcpg_pkg::RAD_BITS-1:0]       i_radius,
    input  logic signed [COORD_BITS-1:0]        i_center_x,
    input  logic signed [COORD_BITS-1:0]        i_center_y,
    output logic signed [COORD_BITS:0]          o_point_x,
    output logic signed [COORD_BITS:0]          o_point_y,
    output logic                                o_last_of_group,
    output logic                                o_circle_done
);
    import mcpg_pkg::*;

    // Arithmetic width wide enough for centre plus or minus a radius
    localparam int AW = ((COORD_BITS > RAD_BITS) ? COORD_BITS : RAD_BITS) + 2;
    localparam int PW = COORD_BITS + 1;

    logic [RAD_BITS-1:0]          r_pos_x, r_pos_y;
    logic [DEC_BITS-1:0]          r_dec;
    logic [COORD_BITS-1:0]        r_cx, r_cy;
    logic                         r_active;
    logic [PW-1:0]                r_pt_x, r_pt_y;
    logic                         r_last, r_done;

    logic [RAD_BITS:0]            nx;
    logic [RAD_BITS:0]            ny;
    logic [RAD_BITS:0]            diff;
    logic [DEC_BITS-1:0]          n_dec;
    logic                         dec_neg;
    logic                         done;
    t_oct                         oct;
    logic [AW-1:0]                cx_ext, cy_ext, a_ext, b_ext, px, py;

    // Midpoint rule for the next octant point
    assign dec_neg = r_dec[DEC_BITS-1];
    assign nx      = {1'b0, r_pos_x} + 1'b1;
    assign ny      = {1'b0, r_pos_y} - {{RAD_BITS{1'b0}}, !dec_neg};
    assign diff    = {1'b0, r_pos_x} - {1'b0, r_pos_y};
    assign n_dec   = dec_neg
                   ? r_dec + {{(DEC_BITS-RAD_BITS-3){1'b0}}, nx, 2'b00} + DEC_STEP_E
                   : r_dec + {{(DEC_BITS-RAD_BITS-3){diff[RAD_BITS]}}, diff, 2'b00}
                     + DEC_STEP_SE;
    assign done    = $signed({1'b0, nx}) > $signed({ny[RAD_BITS], ny});

    // Select the symmetric point for the requested index
    assign oct    = oct_map(i_cmd.idx);
    assign cx_ext = {{(AW-COORD_BITS){r_cx[COORD_BITS-1]}}, r_cx};
    assign cy_ext = {{(AW-COORD_BITS){r_cy[COORD_BITS-1]}}, r_cy};
    assign a_ext  = {{(AW-RAD_BITS){1'b0}}, (oct.swap ? r_pos_y : r_pos_x)};
    assign b_ext  = {{(AW-RAD_BITS){1'b0}}, (oct.swap ? r_pos_x : r_pos_y)};
    assign px     = oct.neg_x ? cx_ext - a_ext : cx_ext + a_ext;
    assign py     = oct.neg_y ? cy_ext - b_ext : cy_ext + b_ext;

    // Circle state: load on start, advance with the eighth point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_dec    <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_active <= 1'b0;
        end else if (i_cmd.load_circle) begin
            r_pos_x  <= '0;
            r_pos_y  <= i_radius;
            r_dec    <= DEC_INIT - {{(DEC_BITS-RAD_BITS-1){1'b0}}, i_radius, 1'b0};
            r_cx     <= i_center_x;
            r_cy     <= i_center_y;
            r_active <= 1'b1;
        end else if (i_cmd.advance) begin
            r_pos_x  <= nx[RAD_BITS-1:0];
            r_pos_y  <= ny[RAD_BITS-1:0];
            r_dec    <= n_dec;
            r_active <= !done;
        end
    end

    // Output point register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_point) begin
            r_pt_x <= px[PW-1:0];
            r_pt_y <= py[PW-1:0];
            r_last <= (i_cmd.idx == IDX_LAST);
            r_done <= (i_cmd.idx == IDX_LAST) && done;
        end
    end

    assign o_stat.active   = r_active;
    assign o_point_x       = r_pt_x;
    assign o_point_y       = r_pt_y;
    assign o_last_of_group = r_last;
    assign o_circle_done   = r_done;

endmodule

// ----- design/midpoint_circle_point_generator.sv -----
// ----------------------------------------------------------------------------
// Midpoint circle point generator
// Rasterises a circle by the midpoint rule, eight symmetric points a step.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata (low bit up)                       tlast          tuser
// s_axis   in   radius, center_x, center_y, zero pad     -              func
// m_axis   out  point_x, point_y, zero pad               last_of_group  circle_done
//
// A start transaction produces nothing.
// A step transaction, while a circle is active, produces eight points, one per
// cycle from a registered output while the output does not stall; the next
// transaction is taken as the eighth point leaves. Output stalls hold the point.
// Reset returns the block to idle with no circle active.
// ----------------------------------------------------------------------------
`include "midpoint_circle_point_generator_defines.svh"

module midpoint_circle_point_generator #(
    parameter int  COORD_BITS = mcpg_pkg::COORD_BITS,
    localparam int IN_W  = ((mcpg_pkg::RAD_BITS + 2 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * (COORD_BITS + 1) + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // radius, center_x, center_y
    input  logic             s_axis_tuser,   // func
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // point_x, point_y
    output logic             m_axis_tlast,
    output logic             m_axis_tuser    // circle_done
);
    import mcpg_pkg::*;

    localparam int PW = COORD_BITS + 1;

    t_dp_cmd                      cmd;
    t_dp_stat                     stat;
    logic signed [COORD_BITS:0]   point_x, point_y;

    // Controller
    mcpg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tuser  (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath
    mcpg_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_radius        (s_axis_tdata[RAD_BITS-1:0]),
        .i_center_x      (s_axis_tdata[RAD_BITS+COORD_BITS-1:RAD_BITS]),
        .i_center_y      (s_axis_tdata[RAD_BITS+2*COORD_BITS-1:RAD_BITS+COORD_BITS]),
        .o_point_x       (point_x),
        .o_point_y       (point_y),
        .o_last_of_group (m_axis_tlast),
        .o_circle_done   (m_axis_tuser)
    );

    // Pack the output point
    always_comb begin
        m_axis_tdata             = '0;
        m_axis_tdata[PW-1:0]     = point_x;
        m_axis_tdata[2*PW-1:PW]  = point_y;
    end

    // Assertions
    `MCPG_ASSERT_SAME(a_done_on_last, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser, m_axis_tlast,
        "circle end flagged on a point that is not the last of its group")
    `MCPG_ASSERT_SAME(a_accept_only_at_group_end, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready && m_axis_tvalid,
        m_axis_tlast && m_axis_tready,
        "input transaction taken in the middle of a point group")
    `MCPG_ASSERT_NEXT(a_idle_after_circle, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tready && m_axis_tuser, !m_axis_tvalid,
        "points produced after the end of a circle")

endmodule

// ----- tb/tb_midpoint_circle_point_generator.sv -----
// ----------------------------------------------------------------------------
// Testbench: midpoint circle point generator
// Streams start and step transactions into the block, with bursty gaps on the
// input and a changing stall pattern on the output. A scoreboard rebuilds the
// eight symmetric points of every step on an active circle and checks each
// output transaction field by field, in order.
// ----------------------------------------------------------------------------

// Rebuild the rasteriser state and hold the points still owed by the block
class circle_scoreboard;

    localparam int PT_W = mcpg_pkg::COORD_BITS + 1;

    typedef struct {
        logic signed [PT_W-1:0] px;
        logic signed [PT_W-1:0] py;
        logic                   last;
        logic                   done;
    } t_point;

    // Shadow state of the rasteriser
    logic [mcpg_pkg::RAD_BITS-1:0]          cur_x;
    logic [mcpg_pkg::RAD_BITS-1:0]          cur_y;
    logic signed [mcpg_pkg::DEC_BITS-1:0]   dec_var;
    logic signed [mcpg_pkg::COORD_BITS-1:0] ctr_x;
    logic signed [mcpg_pkg::COORD_BITS-1:0] ctr_y;
    bit                                     drawing;

    t_point points_due[$];

    int mismatches;
    int starts;
    int steps;
    int idle_steps;
    int points_seen;
    int circles_done;

    function new();
        cur_x        = '0;
        cur_y        = '0;
        dec_var      = '0;
        ctr_x        = '0;
        ctr_y        = '0;
        drawing      = 1'b0;
        mismatches   = 0;
        starts       = 0;
        steps        = 0;
        idle_steps   = 0;
        points_seen  = 0;
        circles_done = 0;
    endfunction

    function int pending();
        return points_due.size();
    endfunction

    function bit circle_active();
        return drawing;
    endfunction

    // Note an accepted input transaction; return the number of points it owes
    function int note_item(input mcpg_pkg::t_func                   kind,
                           input logic [mcpg_pkg::RAD_BITS-1:0]     r,
                           input logic signed [mcpg_pkg::COORD_BITS-1:0] cx,
                           input logic signed [mcpg_pkg::COORD_BITS-1:0] cy);
        int     x;
        int     y;
        int     nx;
        int     ny;
        int     nd;
        int     cxi;
        int     cyi;
        int     dx[8];
        int     dy[8];
        bit     fin;
        t_point p;

        // Load a new circle, dropping any circle still in progress
        if (kind == mcpg_pkg::FUNC_START) begin
            cur_x   = '0;
            cur_y   = r;
            dec_var = 16'(3 - 2 * int'(r));
            ctr_x   = cx;
            ctr_y   = cy;
            drawing = 1'b1;
            starts++;
            return 0;
        end

        if (!drawing) begin
            idle_steps++;
            return 0;
        end

        x   = int'(cur_x);
        y   = int'(cur_y);
        cxi = ctr_x;
        cyi = ctr_y;

        // Advance by the midpoint rule: east move or south-east move
        if (dec_var < 0) begin
            nx = x + 1;
            ny = y;
            nd = int'(dec_var) + 4 * nx + 6;
        end else begin
            nd = int'(dec_var) + 4 * (x - y) + 10;
            nx = x + 1;
            ny = y - 1;
        end
        fin = (nx > ny);

        // Octant order of the eight symmetric points
        dx[0] =  x; dy[0] =  y;
        dx[1] = -x; dy[1] =  y;
        dx[2] =  x; dy[2] = -y;
        dx[3] = -x; dy[3] = -y;
        dx[4] = -y; dy[4] =  x;
        dx[5] = -y; dy[5] = -x;
        dx[6] =  y; dy[6] =  x;
        dx[7] =  y; dy[7] = -x;

        for (int k = 0; k < mcpg_pkg::GROUP_SIZE; k++) begin
            p.px   = PT_W'(cxi + dx[k]);
            p.py   = PT_W'(cyi + dy[k]);
            p.last = (k == mcpg_pkg::GROUP_SIZE - 1);
            p.done = (k == mcpg_pkg::GROUP_SIZE - 1) && fin;
            points_due.push_back(p);
        end

        cur_x   = 12'(nx);
        cur_y   = 12'(ny);
        dec_var = 16'(nd);
        if (fin) begin
            drawing = 1'b0;
            circles_done++;
        end
        steps++;
        return mcpg_pkg::GROUP_SIZE;
    endfunction

    task report(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, want %0d (point %0d)",
                 $realtime, what, got, want, points_seen);
        mismatches++;
    endtask

    // Check one output transaction against the oldest point owed
    task check_point(input logic signed [PT_W-1:0] px,
                     input logic signed [PT_W-1:0] py,
                     input logic                   last,
                     input logic                   done);
        t_point w;
        if (points_due.size() == 0) begin
            report("unrequested point x", int'(px), 0);
        end else begin
            w = points_due.pop_front();
            if (px !== w.px)
                report("point_x", int'(px), int'(w.px));
            if (py !== w.py)
                report("point_y", int'(py), int'(w.py));
            if (last !== w.last)
                report("last_of_group", int'(last), int'(w.last));
            if (done !== w.done)
                report("circle_done", int'(done), int'(w.done));
        end
        points_seen++;
    endtask

endclass

module tb_midpoint_circle_point_generator;

    timeunit 1ns;
    timeprecision 1ps;

    import mcpg_pkg::*;

    localparam int IN_W         = ((RAD_BITS + 2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_W        = ((2 * (COORD_BITS + 1) + 7) / 8) * 8;
    localparam int PT_W         = COORD_BITS + 1;
    localparam int RANDOM_ITEMS = 370;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;   // radius, center_x, center_y, zero pad
    logic             s_axis_tuser;   // func
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;   // point_x, point_y, zero pad
    logic             m_axis_tlast;   // last_of_group
    logic             m_axis_tuser;   // circle_done

    circle_scoreboard sb;

    int burst_left;
    int items_counted;
    bit drained_mid;

    midpoint_circle_point_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard limit on the run
    initial begin
        #4_000_000;
        $display("FAIL midpoint_circle_point_generator");
        $finish;
    end

    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
    endfunction

    // Present one transaction, holding it until the block takes it
    task automatic drive_item(input t_func                        kind,
                              input logic [RAD_BITS-1:0]          r,
                              input logic signed [COORD_BITS-1:0] cx,
                              input logic signed [COORD_BITS-1:0] cy);
        int gap;
        int owed;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
            gap = $urandom_range(1, 6);
        end else begin
            gap = 0;
        end
        burst_left--;

        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W - RAD_BITS - 2 * COORD_BITS){1'b0}}, cy, cx, r};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);

        owed = sb.note_item(kind, r, cx, cy);
        if (kind == FUNC_START || owed > 0)
            items_counted++;
    endtask

    task automatic send_start(input logic [RAD_BITS-1:0]          r,
                              input logic signed [COORD_BITS-1:0] cx,
                              input logic signed [COORD_BITS-1:0] cy);
        drive_item(FUNC_START, r, cx, cy);
    endtask

    // Step with random payload, which the block must ignore
    task automatic send_step();
        drive_item(FUNC_STEP, RAD_BITS'($urandom_range(0, 4095)), rand_coord(), rand_coord());
    endtask

    // Drop tvalid and hold the sender until every owed point has left the block
    task automatic drain_points();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_point(m_axis_tdata[PT_W-1:0], m_axis_tdata[2*PT_W-1:PT_W],
                           m_axis_tlast, m_axis_tuser);
    end

    // Receiver: cycle through free-running, random and bursty stall modes
    initial begin
        int mode;
        int mode_left;
        int hold;
        m_axis_tready = 1'b0;
        mode      = 0;
        mode_left = 0;
        hold      = 0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(40, 200);
            end
            mode_left--;
            case (mode)
                0: begin
                    m_axis_tready <= 1'b1;
                end
                1: begin
                    m_axis_tready <= ($urandom_range(0, 2) != 0);
                end
                default: begin
                    if (hold == 0)
                        hold = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 6)
                                                           : -$urandom_range(1, 8);
                    m_axis_tready <= (hold < 0);
                    hold = (hold > 0) ? hold - 1 : hold + 1;
                end
            endcase
        end
    end

    // Stimulus
    initial begin
        int                          pick;
        int                          sel;
        int                          max_steps;
        int                          n;
        logic [RAD_BITS-1:0]         r;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_START;
        sb            = new();
        burst_left    = 0;
        items_counted = 0;
        drained_mid   = 1'b0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: step while idle, zero radius, tiny circles, extreme centres
        send_step();
        send_start(12'd0, 13'sd0, 13'sd0);
        send_step();
        send_step();
        send_start(12'd1, -13'sd1, 13'sd1);
        send_step();
        send_start(12'd2, 13'sd4095, 13'sd4095);
        while (sb.circle_active()) send_step();
        send_start(12'd4095, 13'sd4095, -13'sd4096);
        repeat (3) send_step();
        // Abandon a circle in progress by starting another
        send_start(12'd4095, -13'sd4096, 13'sd4095);
        repeat (2) send_step();
        send_start(12'd3, -13'sd4096, -13'sd4096);
        while (sb.circle_active()) send_step();
        send_start(12'hAAA, 13'h0555, 13'h1AAA);
        send_step();
        send_start(12'h555, 13'h1AAA, 13'h0555);
        send_step();

        drain_points();

        // Random: mostly whole circles, some abandoned, some noise
        items_counted = 0;
        while (items_counted < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                sel = $urandom_range(0, 99);
                if (sel < 70)
                    r = RAD_BITS'($urandom_range(0, 24));
                else if (sel < 90)
                    r = RAD_BITS'($urandom_range(25, 80));
                else
                    r = RAD_BITS'($urandom_range(0, 4095));
                if (r > 80)
                    max_steps = $urandom_range(1, 12);
                else if ($urandom_range(0, 6) == 0)
                    max_steps = $urandom_range(1, int'(r) + 1);
                else
                    max_steps = 1 << 20;
                send_start(r, rand_coord(), rand_coord());
                n = 0;
                while (sb.circle_active() && n < max_steps) begin
                    send_step();
                    n++;
                end
                if (!sb.circle_active() && $urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 2)) send_step();
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 1) == 0)
                        send_start(RAD_BITS'($urandom_range(0, 4095)), rand_coord(),
                                   rand_coord());
                    else
                        send_step();
                end
            end
            if (!drained_mid && items_counted >= RANDOM_ITEMS / 2) begin
                drained_mid = 1'b1;
                drain_points();
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        // Wait for the last points, then let the pipeline settle
        drain_points();
        repeat (24) @(posedge i_clk);

        $display("Ran %0d circle starts and %0d steps (%0d steps while idle ignored).",
                 sb.starts, sb.steps, sb.idle_steps);
        $display("Compared %0d points; %0d circles reached their final group.",
                 sb.points_seen, sb.circles_done);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS midpoint_circle_point_generator");
        else
            $display("FAIL midpoint_circle_point_generator");
        $finish;
    end

endmodule
